>>> rtl/core/sab_pkg.sv
// Shared types and constants for the straight-alpha over blend pipeline.
package sab_pkg;

	localparam int CH_W     = 8;
	localparam int NUM_CH   = 3;
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;
	localparam int PROD_W   = 2 * CH_W;
	localparam int NUM_W    = PROD_W + 1;
	localparam int DEN_W    = CH_W + 1;
	localparam int DIV_BITS = CH_W;
	// Weight stages, product stage, sum stage, divider stages, output register.
	localparam int PIPE_LAT = DIV_BITS + 5;

	localparam logic [CH_W-1:0]   FULL_SCALE = 8'd255;
	localparam logic [PROD_W-1:0] ROUND_BIAS = 16'd127;

	typedef struct packed {
		logic [CH_W-1:0] src_red;
		logic [CH_W-1:0] src_green;
		logic [CH_W-1:0] src_blue;
		logic [CH_W-1:0] src_alpha;
		logic [CH_W-1:0] dst_red;
		logic [CH_W-1:0] dst_green;
		logic [CH_W-1:0] dst_blue;
		logic [CH_W-1:0] dst_alpha;
	} pixel_in_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic [CH_W-1:0] out_alpha;
	} pixel_out_t;

	typedef struct packed {
		pixel_in_t       pix;
		logic [CH_W-1:0] w2;
		logic [CH_W-1:0] wsum;
	} weight_t;

	typedef struct packed {
		logic                         use_div;
		logic [NUM_CH-1:0][CH_W-1:0] pass;
		logic [CH_W-1:0]             alpha;
	} side_t;

	typedef struct packed {
		logic [NUM_CH-1:0][NUM_W-1:0] num;
		logic [DEN_W-1:0]             den;
		side_t                        side;
	} mix_t;

endpackage

>>> rtl/core/straight_alpha_over_blend.sv
// Top level of the straight-alpha over blend pipeline.
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+--------------------------------
//   pixel   | pix_valid   | pix_stall   | pix   (fg and bg RGBA, 8b each)
//   result  | blend_valid | blend_stall | blend (composited RGBA, 8b each)
//
// One pixel enters per clock unless pix_stall is high; each beat goes through the
// weight, product and sum stages, the divider and the output register. The depth is
// set by the 8-stage divider, one quotient bit per stage, behind four weight and
// product stages. All stages advance together; pix_stall rises only while a result
// beat is held by blend_stall, and no beat is dropped or repeated.
// Reset clears only the valid bits; there is no clearing pass.
module straight_alpha_over_blend (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	output logic                 pix_stall,
	input  sab_pkg::pixel_in_t   pix,
	output logic                 blend_valid,
	input  logic                 blend_stall,
	output sab_pkg::pixel_out_t  blend
);
	import sab_pkg::*;

	logic                adv;
	logic                wt_valid;
	weight_t             wt;
	logic                mix_valid;
	mix_t                mix;
	logic [DIV_BITS-1:0] quo [NUM_CH];

	logic                valid_s [DIV_BITS];
	side_t               side_s  [DIV_BITS];
	logic                blend_valid_q;
	pixel_out_t          blend_q;
	pixel_out_t          blend_next;
	side_t               side_last;

	assign adv       = !(blend_valid_q && blend_stall);
	assign pix_stall = !adv;

	sab_weight u_weight (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.pix_valid (pix_valid),
		.pix       (pix),
		.wt_valid  (wt_valid),
		.wt        (wt)
	);

	sab_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.wt_valid  (wt_valid),
		.wt        (wt),
		.mix_valid (mix_valid),
		.mix       (mix)
	);

	for (genvar c = 0; c < NUM_CH; c++) begin : g_div
		sab_div u_div (
			.clk (clk),
			.adv (adv),
			.num (mix.num[c]),
			.den (mix.den),
			.quo (quo[c])
		);
	end

	// The pass-through colors and alpha ride alongside the divider stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_BITS; k++) begin
				valid_s[k] <= 1'b0;
			end
			blend_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s[0] <= mix_valid;
			for (int k = 1; k < DIV_BITS; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
			blend_valid_q <= valid_s[DIV_BITS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= mix.side;
			for (int k = 1; k < DIV_BITS; k++) begin
				side_s[k] <= side_s[k-1];
			end
			blend_q <= blend_next;
		end
	end

	assign side_last = side_s[DIV_BITS-1];

	always_comb begin
		blend_next.out_red   = side_last.use_div ? quo[CH_RED]   : side_last.pass[CH_RED];
		blend_next.out_green = side_last.use_div ? quo[CH_GREEN] : side_last.pass[CH_GREEN];
		blend_next.out_blue  = side_last.use_div ? quo[CH_BLUE]  : side_last.pass[CH_BLUE];
		blend_next.out_alpha = side_last.alpha;
	end

	assign blend_valid = blend_valid_q;
	assign blend       = blend_q;

endmodule

>>> rtl/core/sab_weight.sv
// Background weight and output alpha, two pipeline stages.
module sab_weight (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                pix_valid,
	input  sab_pkg::pixel_in_t  pix,
	output logic                wt_valid,
	output sab_pkg::weight_t    wt
);
	import sab_pkg::*;

	logic              valid_s1;
	pixel_in_t         pix_s1;
	logic [PROD_W-1:0] prod_s1;
	logic              valid_s2;
	weight_t           wt_s2;

	logic [CH_W-1:0]   inv;
	logic [PROD_W:0]   biased;
	logic [PROD_W:0]   folded;
	logic [CH_W-1:0]   w2;
	logic [CH_W:0]     wsum;

	assign inv = FULL_SCALE - pix.src_alpha;

	// Rounded division by 255: floor((x + 127) / 255), done as y + (y >> 8) + 1, then >> 8.
	assign biased = (PROD_W+1)'(prod_s1) + (PROD_W+1)'(ROUND_BIAS);
	assign folded = biased + (biased >> CH_W) + (PROD_W+1)'(1);
	assign w2     = folded[CH_W +: CH_W];
	assign wsum   = {1'b0, pix_s1.src_alpha} + {1'b0, w2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pix_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1      <= pix;
			prod_s1     <= PROD_W'(pix.dst_alpha) * PROD_W'(inv);
			wt_s2.pix   <= pix_s1;
			wt_s2.w2    <= w2;
			wt_s2.wsum  <= wsum[CH_W] ? FULL_SCALE : wsum[CH_W-1:0];
		end
	end

	assign wt_valid = valid_s2;
	assign wt       = wt_s2;

endmodule

>>> rtl/core/sab_mix.sv
// Per-channel weighted products and the rounded dividend, two pipeline stages.
module sab_mix (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              wt_valid,
	input  sab_pkg::weight_t  wt,
	output logic              mix_valid,
	output sab_pkg::mix_t     mix
);
	import sab_pkg::*;

	logic              valid_s3;
	logic [PROD_W-1:0] prod_fg_s3 [NUM_CH];
	logic [PROD_W-1:0] prod_bg_s3 [NUM_CH];
	side_t             side_s3;
	logic              valid_s4;
	mix_t              mix_s4;

	logic [CH_W-1:0]   fg [NUM_CH];
	logic [CH_W-1:0]   bg [NUM_CH];
	side_t             side;
	logic [NUM_W:0]    dividend [NUM_CH];

	assign fg[CH_RED]   = wt.pix.src_red;
	assign fg[CH_GREEN] = wt.pix.src_green;
	assign fg[CH_BLUE]  = wt.pix.src_blue;
	assign bg[CH_RED]   = wt.pix.dst_red;
	assign bg[CH_GREEN] = wt.pix.dst_green;
	assign bg[CH_BLUE]  = wt.pix.dst_blue;

	// A transparent foreground passes the background color; a zero background
	// weight passes the foreground color. Only the rest needs the divider.
	always_comb begin
		side.use_div = (wt.pix.src_alpha != '0) && (wt.w2 != '0);
		side.alpha   = wt.wsum;
		for (int c = 0; c < NUM_CH; c++) begin
			side.pass[c] = (wt.pix.src_alpha == '0) ? bg[c] : fg[c];
		end
	end

	// Dividend is 2 * (fg * a + bg * w2) + wsum, so that the quotient by 2 * wsum
	// rounds half up.
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			dividend[c] = ((NUM_W+1)'(prod_fg_s3[c]) + (NUM_W+1)'(prod_bg_s3[c])) << 1;
			dividend[c] = dividend[c] + (NUM_W+1)'(side_s3.alpha);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= wt_valid;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < NUM_CH; c++) begin
				prod_fg_s3[c] <= PROD_W'(fg[c]) * PROD_W'(wt.pix.src_alpha);
				prod_bg_s3[c] <= PROD_W'(bg[c]) * PROD_W'(wt.w2);
				mix_s4.num[c] <= dividend[c][NUM_W-1:0];
			end
			side_s3     <= side;
			mix_s4.den  <= {side_s3.alpha, 1'b0};
			mix_s4.side <= side_s3;
		end
	end

	assign mix_valid = valid_s4;
	assign mix       = mix_s4;

endmodule

>>> rtl/core/sab_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module sab_div (
	input  logic                          clk,
	input  logic                          adv,
	input  logic [sab_pkg::NUM_W-1:0]     num,
	input  logic [sab_pkg::DEN_W-1:0]     den,
	output logic [sab_pkg::DIV_BITS-1:0]  quo
);
	import sab_pkg::*;

	logic [NUM_W-1:0]    rem_s [DIV_BITS];
	logic [DEN_W-1:0]    den_s [DIV_BITS];
	logic [DIV_BITS-1:0] quo_s [DIV_BITS];

	logic [NUM_W-1:0]    rem_in [DIV_BITS];
	logic [DEN_W-1:0]    den_in [DIV_BITS];
	logic [DIV_BITS-1:0] quo_in [DIV_BITS];
	logic [NUM_W-1:0]    dsh    [DIV_BITS];
	logic                take   [DIV_BITS];

	always_comb begin
		rem_in[0] = num;
		den_in[0] = den;
		quo_in[0] = '0;
		for (int k = 1; k < DIV_BITS; k++) begin
			rem_in[k] = rem_s[k-1];
			den_in[k] = den_s[k-1];
			quo_in[k] = quo_s[k-1];
		end
		// Stage k settles quotient bit DIV_BITS-1-k.
		for (int k = 0; k < DIV_BITS; k++) begin
			dsh[k]  = NUM_W'(den_in[k]) << (DIV_BITS - 1 - k);
			take[k] = rem_in[k] >= dsh[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < DIV_BITS; k++) begin
				rem_s[k] <= take[k] ? rem_in[k] - dsh[k] : rem_in[k];
				den_s[k] <= den_in[k];
				quo_s[k] <= {quo_in[k][DIV_BITS-2:0], take[k]};
			end
		end
	end

	assign quo = quo_s[DIV_BITS-1];

endmodule

>>> rtl/core/sab_check.sv
// Port-level checks for the blend pipeline, bound to the top level.
module sab_check (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 pix_valid,
	input logic                 pix_stall,
	input sab_pkg::pixel_in_t   pix,
	input logic                 blend_valid,
	input logic                 blend_stall,
	input sab_pkg::pixel_out_t  blend
);
	import sab_pkg::*;

	localparam int RUN_W = $clog2(PIPE_LAT + 1);

	// Consecutive edges without a result stall; the pipeline moves on each one.
	logic [RUN_W-1:0] run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (blend_stall) begin
			run_q <= '0;
		end else if (run_q != RUN_W'(PIPE_LAT)) begin
			run_q <= run_q + RUN_W'(1);
		end
	end

	a_stall_only_on_held_beat: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall == (blend_valid && blend_stall))
		else $error("input stall does not follow a held result beat");

	a_held_payload: assert property (@(posedge clk) disable iff (!arst_n)
		blend_valid && blend_stall |=> $stable(blend))
		else $error("result payload changed while stalled");

	// An opaque foreground pixel comes out unchanged after the full pipeline depth.
	a_opaque_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q == RUN_W'(PIPE_LAT)) &&
		$past(pix_valid && !pix_stall && pix.src_alpha == FULL_SCALE, PIPE_LAT)
		|-> blend_valid && blend.out_alpha == FULL_SCALE &&
		blend.out_red == $past(pix.src_red, PIPE_LAT) &&
		blend.out_green == $past(pix.src_green, PIPE_LAT) &&
		blend.out_blue == $past(pix.src_blue, PIPE_LAT))
		else $error("opaque foreground not passed through");

	// A transparent foreground leaves the background pixel as it was.
	a_clear_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q == RUN_W'(PIPE_LAT)) &&
		$past(pix_valid && !pix_stall && pix.src_alpha == '0, PIPE_LAT)
		|-> blend_valid && blend.out_alpha == $past(pix.dst_alpha, PIPE_LAT) &&
		blend.out_red == $past(pix.dst_red, PIPE_LAT) &&
		blend.out_green == $past(pix.dst_green, PIPE_LAT) &&
		blend.out_blue == $past(pix.dst_blue, PIPE_LAT))
		else $error("transparent foreground altered the background");

endmodule

bind straight_alpha_over_blend sab_check u_sab_check (.*);

>>> verif/sab_blend_checker.sv
// Watches both channels of the over blend, predicts every result beat and compares it.
module sab_blend_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	input  logic                pix_stall,
	input  sab_pkg::pixel_in_t  pix,
	input  logic                blend_valid,
	input  logic                blend_stall,
	input  sab_pkg::pixel_out_t blend,
	output int                  fail_count,
	output int                  pending
);
	import sab_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	pixel_out_t expected_blends[$];

	// Round num/den to nearest with halves going up.
	function automatic int unsigned round_div(int unsigned num, int unsigned den);
		return (2 * num + den) / (2 * den);
	endfunction

	function automatic logic [CH_W-1:0] weighted_mix(
		logic [CH_W-1:0] fg, logic [CH_W-1:0] bg,
		int unsigned w_fg, int unsigned w_bg, int unsigned w_sum);
		int unsigned q;
		if (w_fg == 0)
			return bg;
		if (w_bg == 0)
			return fg;
		q = round_div(fg * w_fg + bg * w_bg, w_sum);
		return q[CH_W-1:0];
	endfunction

	function automatic pixel_out_t over_blend(pixel_in_t p);
		int unsigned full;
		int unsigned w_bg;
		int unsigned w_sum;
		pixel_out_t r;
		full = FULL_SCALE;
		w_bg = round_div(p.dst_alpha * (full - p.src_alpha), full);
		w_sum = p.src_alpha + w_bg;
		if (w_sum > full)
			w_sum = full;
		r.out_red   = weighted_mix(p.src_red, p.dst_red, p.src_alpha, w_bg, w_sum);
		r.out_green = weighted_mix(p.src_green, p.dst_green, p.src_alpha, w_bg, w_sum);
		r.out_blue  = weighted_mix(p.src_blue, p.dst_blue, p.src_alpha, w_bg, w_sum);
		r.out_alpha = w_sum[CH_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		pixel_out_t want;
		int fails;
		fails = fail_count;
		if (arst_n) begin
			if (pix_valid && !pix_stall)
				expected_blends.push_back(over_blend(pix));
			if (blend_valid && !blend_stall) begin
				if (expected_blends.size() == 0) begin
					if (fails < 10)
						$display("unexpected result beat: %h", blend);
					fails++;
				end else begin
					want = expected_blends.pop_front();
					if (blend !== want) begin
						if (fails < 10)
							$display("exp r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
								want.out_red, want.out_green, want.out_blue, want.out_alpha,
								blend.out_red, blend.out_green, blend.out_blue,
								blend.out_alpha);
						fails++;
					end
				end
			end
		end
		fail_count <= fails;
		pending <= expected_blends.size();
	end

endmodule

>>> verif/tb_straight_alpha_over_blend.sv
// Stimulus and verdict for the straight-alpha over blend, with the checker beside the block.
module tb_straight_alpha_over_blend;
	import sab_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 200;
	localparam int RAND_PER_PHASE = 270;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       pix_valid = 1'b0;
	logic       pix_stall;
	pixel_in_t  pix = '0;
	logic       blend_valid;
	logic       blend_stall = 1'b0;
	pixel_out_t blend;

	int fail_count;
	int pending;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic hold_go = 1'b0;
	int cycles = 0;

	straight_alpha_over_blend dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.pix         (pix),
		.blend_valid (blend_valid),
		.blend_stall (blend_stall),
		.blend       (blend)
	);

	sab_blend_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.pix         (pix),
		.blend_valid (blend_valid),
		.blend_stall (blend_stall),
		.blend       (blend),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("straight_alpha_over_blend verification failed");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off that lets the pipe fill up.
	int hold_count = 0;
	always @(posedge clk) begin
		if (hold_go && hold_count < HOLD_CYCLES) begin
			blend_stall <= 1'b1;
			hold_count++;
		end else begin
			blend_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic send_pixel(input pixel_in_t p);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix <= p;
		pix_valid <= 1'b1;
		@(posedge clk);
		while (pix_stall)
			@(posedge clk);
	endtask

	// Lowers valid on the edge of the last accepted beat and waits until every result is back.
	task automatic drain_results();
		pix_valid <= 1'b0;
		// The count seen right at the accepting edge does not yet include that beat.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [CH_W-1:0] pick_alpha();
		case ($urandom_range(7))
			0: return '0;
			1: return FULL_SCALE;
			2: return CH_W'($urandom_range(0, 3));
			3: return CH_W'($urandom_range(250, 255));
			default: return CH_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pixel_in_t random_pixel();
		pixel_in_t p;
		p = {$urandom, $urandom};
		if ($urandom_range(3) != 0) begin
			p.src_alpha = pick_alpha();
			p.dst_alpha = pick_alpha();
		end
		// Near-opaque foreground over faint background drives the background weight to zero.
		if ($urandom_range(9) == 0) begin
			p.src_alpha = CH_W'($urandom_range(200, 255));
			p.dst_alpha = CH_W'($urandom_range(0, 2));
		end
		return p;
	endfunction

	function automatic pixel_in_t make_pixel(
		logic [CH_W-1:0] sr, logic [CH_W-1:0] sg, logic [CH_W-1:0] sb, logic [CH_W-1:0] sa,
		logic [CH_W-1:0] dr, logic [CH_W-1:0] dg, logic [CH_W-1:0] db, logic [CH_W-1:0] da);
		pixel_in_t p;
		p.src_red = sr;
		p.src_green = sg;
		p.src_blue = sb;
		p.src_alpha = sa;
		p.dst_red = dr;
		p.dst_green = dg;
		p.dst_blue = db;
		p.dst_alpha = da;
		return p;
	endfunction

	task automatic random_phase(input int s_pct, input int r_pct, input logic with_hold);
		send_idle_pct <= s_pct;
		recv_idle_pct <= r_pct;
		if (with_hold)
			hold_go <= 1'b1;
		repeat (RAND_PER_PHASE)
			send_pixel(random_pixel());
		drain_results();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct <= 11;
		recv_idle_pct <= 81;
		send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
		// Transparent foreground passes the background through.
		send_pixel(make_pixel(8'hff, 8'h12, 8'h34, 8'h00, 8'h56, 8'h78, 8'h9a, 8'hc3));
		send_pixel(make_pixel(8'haa, 8'h55, 8'hff, 8'h00, 8'h55, 8'haa, 8'h00, 8'h00));
		send_pixel(make_pixel(8'h00, 8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 8'hff, 8'hff));
		// Opaque foreground or a vanishing background weight passes the foreground through.
		send_pixel(make_pixel(8'h11, 8'h22, 8'h33, 8'hff, 8'hee, 8'hdd, 8'hcc, 8'hff));
		send_pixel(make_pixel(8'haa, 8'h55, 8'haa, 8'hfe, 8'h55, 8'haa, 8'h55, 8'h01));
		send_pixel(make_pixel(8'h80, 8'h40, 8'h20, 8'h01, 8'h10, 8'h08, 8'h04, 8'h00));
		send_pixel(make_pixel(8'hff, 8'h00, 8'hff, 8'hc8, 8'h00, 8'hff, 8'h00, 8'h02));
		// Both weights present.
		send_pixel(make_pixel(8'hff, 8'h00, 8'h80, 8'h01, 8'h00, 8'hff, 8'h7f, 8'hff));
		send_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'h80, 8'h00, 8'h00, 8'h00, 8'hff));
		send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h80, 8'hff, 8'hff, 8'hff, 8'hff));
		send_pixel(make_pixel(8'h55, 8'haa, 8'h55, 8'h7f, 8'haa, 8'h55, 8'haa, 8'h80));
		send_pixel(make_pixel(8'h01, 8'hfe, 8'h7f, 8'h01, 8'hfe, 8'h01, 8'h80, 8'h01));
		send_pixel(make_pixel(8'hff, 8'h00, 8'hff, 8'hfe, 8'h00, 8'hff, 8'h00, 8'hff));
		send_pixel(make_pixel(8'h64, 8'hc8, 8'h32, 8'h40, 8'h96, 8'h0a, 8'hfa, 8'hc0));
		send_pixel(make_pixel(8'h7f, 8'h80, 8'h81, 8'h03, 8'h81, 8'h80, 8'h7f, 8'h05));
		send_pixel(make_pixel(8'hff, 8'hff, 8'h00, 8'h02, 8'h00, 8'h00, 8'hff, 8'h01));
		drain_results();

		random_phase(11, 81, 1'b0);
		random_phase(81, 11, 1'b0);
		random_phase(0, 0, 1'b1);

		repeat (4 * PIPE_LAT) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("straight_alpha_over_blend verification clean");
		else
			$display("straight_alpha_over_blend verification failed");
		$finish;
	end

endmodule
